// ===== hw/rtl/wctc_pkg.sv =====
package wctc_pkg;

	localparam int OFFSET_W   = 40;
	localparam int LEN_W      = 19;
	localparam int CHUNK_W    = 17;
	localparam int SLOT_W     = 16;
	localparam int SLOT_BYTES = 65536;
	localparam int SLOT_COUNT = 16;
	localparam int IDX_W      = 4;
	localparam int TAG_W      = OFFSET_W - SLOT_W;
	localparam int MAX_SLOTS_PER_REQUEST = 4;

	localparam logic [LEN_W-1:0]   LEN_CAP   = LEN_W'(MAX_SLOTS_PER_REQUEST * SLOT_BYTES);
	localparam logic [CHUNK_W-1:0] SLOT_SPAN = CHUNK_W'(SLOT_BYTES);

	localparam logic [1:0] KIND_HIT      = 2'd0;
	localparam logic [1:0] KIND_MISS     = 2'd1;
	localparam logic [1:0] KIND_PREFETCH = 2'd2;
	localparam logic [1:0] KIND_NONE     = 2'd3;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} tag_rd_req_t;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
	} tag_rd_rsp_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [TAG_W-1:0] tag;
	} tag_wr_req_t;

endpackage

// ===== hw/rtl/wctc_tag_store.sv =====
module wctc_tag_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wctc_pkg::tag_rd_req_t rd_req,
	output wctc_pkg::tag_rd_rsp_t rd_rsp,
	input  wctc_pkg::tag_wr_req_t wr_req
);
	import wctc_pkg::*;

	logic [TAG_W-1:0]      tag_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;
	tag_rd_rsp_t           rsp_q;

	// tag array: no reset, guarded by valid bits
	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			tag_mem[wr_req.idx] <= wr_req.tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_req.en) begin
			valid_q[wr_req.idx] <= 1'b1;
		end
	end

	// registered read; forward a same-cycle write to the same entry
	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			if (wr_req.en && wr_req.idx == rd_req.idx) begin
				rsp_q.valid <= 1'b1;
				rsp_q.tag   <= wr_req.tag;
			end else begin
				rsp_q.valid <= valid_q[rd_req.idx];
				rsp_q.tag   <= tag_mem[rd_req.idx];
			end
		end
	end

	assign rd_rsp = rsp_q;

endmodule

// ===== hw/rtl/window_cache_tag_controller_unit.sv =====
// Tag controller for a direct-mapped read cache with next-block prefetch.
//
// Request channel: present request_offset, request_length and file_size
// with start high; the transaction is taken at an edge where start is high
// and busy is low. busy stays high until the last result of the request.
// Result channel: each result sits on the result ports for one cycle with
// result_valid high; the receiver cannot stall it. last marks the final
// result of a request, which also carries read_length.
// Config channel: cfg_valid/cfg_data write prefetch_enable; cfg_ready is
// always high. Write it only while busy is low.
//
// Sequence: IDLE takes the request, CLIP clips it against the file end,
// then LOOK handles each chunk in turn (up to five). A prefetch check adds
// the PFL state, and PFOUT follows when a held final chunk is followed by
// an issued prefetch. The pace is set by the tag memory: every chunk and
// the prefetch each need one read-modify-write, and its separate read and
// write ports let the read for the next block overlap the write of the
// current one.
// Reset clears all valid bits and prefetch_enable; the block comes out of
// reset idle and ready.
module window_cache_tag_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [wctc_pkg::OFFSET_W-1:0] request_offset,
	input  logic [wctc_pkg::LEN_W-1:0]    request_length,
	input  logic [wctc_pkg::OFFSET_W-1:0] file_size,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	output logic                          result_valid,
	output logic [1:0]                    kind,
	output logic [wctc_pkg::IDX_W-1:0]    slot_index,
	output logic [wctc_pkg::OFFSET_W-1:0] block_address,
	output logic [wctc_pkg::SLOT_W-1:0]   start_in_slot,
	output logic [wctc_pkg::CHUNK_W-1:0]  chunk_length,
	output logic [wctc_pkg::LEN_W-1:0]    read_length,
	output logic                          last
);
	import wctc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLIP  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_PFL   = 3'd3;
	localparam logic [2:0] ST_PFOUT = 3'd4;

	logic [2:0]          state_q;
	logic                pf_en_q;

	// request context
	logic [OFFSET_W-1:0] off_q;
	logic [OFFSET_W-1:0] flen_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    remain_q;

	// final chunk held back until the prefetch check settles last
	logic                pend_valid_q;
	logic                pend_hit_q;
	logic [TAG_W-1:0]    pend_blk_q;
	logic [SLOT_W-1:0]   pend_start_q;
	logic [CHUNK_W-1:0]  pend_clen_q;

	// result registers
	logic                res_valid_q;
	logic [1:0]          res_kind_q;
	logic [IDX_W-1:0]    res_slot_q;
	logic [OFFSET_W-1:0] res_addr_q;
	logic [SLOT_W-1:0]   res_start_q;
	logic [CHUNK_W-1:0]  res_clen_q;
	logic [LEN_W-1:0]    res_rlen_q;
	logic                res_last_q;

	tag_rd_req_t rd_req;
	tag_rd_rsp_t rd_rsp;
	tag_wr_req_t wr_req;

	logic [TAG_W-1:0]    cur_blk;
	logic [IDX_W-1:0]    cur_idx;
	logic [IDX_W-1:0]    next_idx;
	logic [TAG_W-1:0]    next_blk;
	logic [SLOT_W-1:0]   cur_start;
	logic [CHUNK_W-1:0]  avail;
	logic                is_final;
	logic [CHUNK_W-1:0]  chunk_len;
	logic [CHUNK_W-1:0]  end_low;
	logic                pf_cand;
	logic                hit;
	logic [OFFSET_W:0]   room;
	logic                past_end;
	logic [LEN_W-1:0]    clip_len;
	logic                clip_pf;

	wctc_tag_store u_tag_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_req (rd_req),
		.rd_rsp (rd_rsp),
		.wr_req (wr_req)
	);

	// chunk arithmetic on the current offset
	assign cur_blk   = off_q[OFFSET_W-1:SLOT_W];
	assign cur_idx   = off_q[SLOT_W+IDX_W-1:SLOT_W];
	assign next_idx  = cur_idx + 1'b1;
	assign next_blk  = cur_blk + 1'b1;
	assign cur_start = off_q[SLOT_W-1:0];
	assign avail     = SLOT_SPAN - {1'b0, cur_start};
	assign is_final  = LEN_W'(avail) >= remain_q;
	assign chunk_len = is_final ? remain_q[CHUNK_W-1:0] : avail;
	// end offset within the slot; a full slot wraps to zero in the low bits
	assign end_low   = {1'b0, cur_start} + chunk_len;
	assign pf_cand   = pf_en_q && end_low[SLOT_W-1];
	assign hit       = rd_rsp.valid && rd_rsp.tag == cur_blk;

	// clip against the file end
	assign room     = {1'b0, flen_q} - {1'b0, off_q};
	assign past_end = room[OFFSET_W] || room == '0;
	assign clip_len = (room[OFFSET_W-1:0] < OFFSET_W'(len_q)) ? room[LEN_W-1:0] : len_q;
	assign clip_pf  = pf_en_q && off_q[SLOT_W-1];

	// tag memory requests: read the following block while the current one updates
	always_comb begin
		rd_req = '0;
		wr_req = '0;
		unique case (state_q)
			ST_CLIP: begin
				rd_req.en  = 1'b1;
				rd_req.idx = (clip_len != '0) ? cur_idx : next_idx;
			end
			ST_LOOK: begin
				rd_req.en  = 1'b1;
				rd_req.idx = next_idx;
				wr_req.en  = !hit;
				wr_req.idx = cur_idx;
				wr_req.tag = cur_blk;
			end
			ST_PFL: begin
				wr_req.en  = !hit;
				wr_req.idx = cur_idx;
				wr_req.tag = cur_blk;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			pf_en_q <= cfg_data;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					pend_valid_q <= 1'b0;
					if (past_end || (clip_len == '0 && !clip_pf)) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (clip_len != '0) begin
						state_q <= ST_LOOK;
					end else begin
						state_q <= ST_PFL;
					end
				end
				ST_LOOK: begin
					if (!is_final) begin
						res_valid_q <= 1'b1;
					end else if (pf_cand) begin
						pend_valid_q <= 1'b1;
						state_q      <= ST_PFL;
					end else begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_PFL: begin
					res_valid_q <= 1'b1;
					if (!hit && pend_valid_q) begin
						state_q <= ST_PFOUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PFOUT: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				off_q  <= request_offset;
				flen_q <= file_size;
				len_q  <= (request_length > LEN_CAP) ? LEN_CAP : request_length;
			end
			ST_CLIP: begin
				len_q    <= clip_len;
				remain_q <= clip_len;
				if (clip_len == '0) begin
					off_q <= {next_blk, {SLOT_W{1'b0}}};
				end
				// nothing read
				res_kind_q  <= KIND_NONE;
				res_slot_q  <= '0;
				res_addr_q  <= '0;
				res_start_q <= '0;
				res_clen_q  <= '0;
				res_rlen_q  <= '0;
				res_last_q  <= 1'b1;
			end
			ST_LOOK: begin
				// advance to the next block; on the final chunk this is the prefetch block
				off_q    <= {next_blk, {SLOT_W{1'b0}}};
				remain_q <= remain_q - LEN_W'(chunk_len);
				pend_hit_q   <= hit;
				pend_blk_q   <= cur_blk;
				pend_start_q <= cur_start;
				pend_clen_q  <= chunk_len;
				res_kind_q  <= hit ? KIND_HIT : KIND_MISS;
				res_slot_q  <= cur_idx;
				res_addr_q  <= {cur_blk, {SLOT_W{1'b0}}};
				res_start_q <= cur_start;
				res_clen_q  <= chunk_len;
				res_rlen_q  <= is_final ? len_q : '0;
				res_last_q  <= is_final;
			end
			ST_PFL: begin
				if (pend_valid_q) begin
					// drop the held chunk out; it is last only if no prefetch follows
					res_kind_q  <= pend_hit_q ? KIND_HIT : KIND_MISS;
					res_slot_q  <= pend_blk_q[IDX_W-1:0];
					res_addr_q  <= {pend_blk_q, {SLOT_W{1'b0}}};
					res_start_q <= pend_start_q;
					res_clen_q  <= pend_clen_q;
					res_rlen_q  <= hit ? len_q : '0;
					res_last_q  <= hit;
				end else begin
					res_kind_q  <= hit ? KIND_NONE : KIND_PREFETCH;
					res_slot_q  <= hit ? '0 : cur_idx;
					res_addr_q  <= hit ? '0 : off_q;
					res_start_q <= '0;
					res_clen_q  <= '0;
					res_rlen_q  <= len_q;
					res_last_q  <= 1'b1;
				end
			end
			ST_PFOUT: begin
				res_kind_q  <= KIND_PREFETCH;
				res_slot_q  <= cur_idx;
				res_addr_q  <= off_q;
				res_start_q <= '0;
				res_clen_q  <= '0;
				res_rlen_q  <= len_q;
				res_last_q  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy          = state_q != ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign result_valid  = res_valid_q;
	assign kind          = res_kind_q;
	assign slot_index    = res_slot_q;
	assign block_address = res_addr_q;
	assign start_in_slot = res_start_q;
	assign chunk_length  = res_clen_q;
	assign read_length   = res_rlen_q;
	assign last          = res_last_q;

	// the request ends exactly when its last result shows
	a_end_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && last))
		else $error("busy dropped without a last result");

	a_result_in_request: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result outside a request");

	a_take_request: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");

	a_none_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_NONE) |-> (last && chunk_length == '0 && read_length == '0))
		else $error("nothing-read result carries data");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import wctc_pkg::*;

	// Kinds of work the driver pulls from its queue: a read request, a write of
	// prefetch_enable, or a pause until every predicted result has come back.
	typedef enum logic [1:0] {
		STEP_READ,
		STEP_CFG,
		STEP_DRAIN
	} step_kind_t;

	typedef struct packed {
		step_kind_t            what;
		logic [OFFSET_W-1:0]   off;
		logic [LEN_W-1:0]      len;
		logic [OFFSET_W-1:0]   flen;
		logic                  pf;
	} host_step_t;

	// One result transaction as the block should present it.
	typedef struct packed {
		logic [1:0]            kind;
		logic [IDX_W-1:0]      slot;
		logic [OFFSET_W-1:0]   addr;
		logic [SLOT_W-1:0]     offs;
		logic [CHUNK_W-1:0]    clen;
		logic [LEN_W-1:0]      rlen;
		logic                  fin;
	} read_item_t;

	localparam logic [OFFSET_W-1:0] TOP_OFFSET = '1;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 4000;
	localparam int QUIET_FROM    = 120;
	localparam int QUIET_TO      = 180;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [OFFSET_W-1:0]   request_offset = '0;
	logic [LEN_W-1:0]      request_length = '0;
	logic [OFFSET_W-1:0]   file_size = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data = 1'b0;
	logic                  result_valid;
	logic [1:0]            kind;
	logic [IDX_W-1:0]      slot_index;
	logic [OFFSET_W-1:0]   block_address;
	logic [SLOT_W-1:0]     start_in_slot;
	logic [CHUNK_W-1:0]    chunk_length;
	logic [LEN_W-1:0]      read_length;
	logic                  last;

	window_cache_tag_controller_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request_offset (request_offset),
		.request_length (request_length),
		.file_size      (file_size),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.kind           (kind),
		.slot_index     (slot_index),
		.block_address  (block_address),
		.start_in_slot  (start_in_slot),
		.chunk_length   (chunk_length),
		.read_length    (read_length),
		.last           (last)
	);

	// Shadow copy of the tag store and the prefetch switch, advanced in the
	// order that read transactions are taken.
	logic [TAG_W-1:0]  shadow_tag [SLOT_COUNT];
	logic              shadow_ok  [SLOT_COUNT];
	logic              prefetch_on = 1'b0;

	host_step_t  host_steps [$];
	read_item_t  due_items  [$];
	int          fail_count = 0;
	int          reads_sent = 0;
	int          settle_cnt = 0;
	int          stall_cycles = 0;

	initial begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			shadow_tag[i] = '0;
			shadow_ok[i]  = 1'b0;
		end
	end

	initial begin
		forever #1 clk = ~clk;
	end

	// Hold reset low from time zero, then release it for good.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	// Clip the request, walk it slot by slot against the shadow tags, then run
	// the next-block prefetch check; queue every result the block owes us.
	function automatic void split_and_lookup(input logic [OFFSET_W-1:0] off_in,
			input logic [LEN_W-1:0] len_in, input logic [OFFSET_W-1:0] flen);
		read_item_t           seq [MAX_SLOTS_PER_REQUEST + 2];
		logic [OFFSET_W-1:0]  pos;
		logic [LEN_W-1:0]     len;
		logic [LEN_W-1:0]     remain;
		logic [CHUNK_W-1:0]   piece;
		logic [TAG_W-1:0]     blk;
		logic [IDX_W-1:0]     idx;
		logic                 in_file;
		int                   n;

		n = 0;
		pos = off_in;
		in_file = off_in < flen;
		// Saturate overlong requests first, then clip against the file end.
		len = (len_in > LEN_CAP) ? LEN_CAP : len_in;
		if (!in_file)
			len = '0;
		else if ({1'b0, off_in} + len > {1'b0, flen})
			len = LEN_W'(flen - off_in);
		remain = len;

		while (remain != 0 && n < MAX_SLOTS_PER_REQUEST + 1) begin
			blk = pos[OFFSET_W-1:SLOT_W];
			idx = blk[IDX_W-1:0];
			piece = SLOT_SPAN - CHUNK_W'(pos[SLOT_W-1:0]);
			if (piece > remain)
				piece = CHUNK_W'(remain);
			seq[n] = '0;
			seq[n].kind = (shadow_ok[idx] && shadow_tag[idx] == blk) ? KIND_HIT : KIND_MISS;
			seq[n].slot = idx;
			seq[n].addr = {blk, {SLOT_W{1'b0}}};
			seq[n].offs = pos[SLOT_W-1:0];
			seq[n].clen = piece;
			// A miss installs the tag right away: fetches never fail here.
			shadow_tag[idx] = blk;
			shadow_ok[idx]  = 1'b1;
			pos = pos + piece;
			remain = remain - piece;
			n++;
		end

		// End offset in the upper half of its slot: look at the next block,
		// which wraps around at the top of the 40-bit space.
		if (in_file && prefetch_on && pos[SLOT_W-1]) begin
			blk = pos[OFFSET_W-1:SLOT_W] + 1'b1;
			idx = blk[IDX_W-1:0];
			if (!(shadow_ok[idx] && shadow_tag[idx] == blk)) begin
				shadow_tag[idx] = blk;
				shadow_ok[idx]  = 1'b1;
				seq[n] = '0;
				seq[n].kind = KIND_PREFETCH;
				seq[n].slot = idx;
				seq[n].addr = {blk, {SLOT_W{1'b0}}};
				n++;
			end
		end

		if (n == 0) begin
			seq[0] = '0;
			seq[0].kind = KIND_NONE;
			n = 1;
		end
		seq[n-1].rlen = len;
		seq[n-1].fin  = 1'b1;
		for (int i = 0; i < n; i++)
			due_items.push_back(seq[i]);
	endfunction

	function automatic logic [OFFSET_W-1:0] any_offset();
		return {8'($urandom), $urandom};
	endfunction

	function automatic void queue_read(input logic [OFFSET_W-1:0] off,
			input logic [LEN_W-1:0] len, input logic [OFFSET_W-1:0] flen);
		host_step_t s;
		s = '0;
		s.what = STEP_READ;
		s.off  = off;
		s.len  = len;
		s.flen = flen;
		host_steps.push_back(s);
	endfunction

	function automatic void queue_ctrl(input step_kind_t what, input logic pf);
		host_step_t s;
		s = '0;
		s.what = what;
		s.pf   = pf;
		host_steps.push_back(s);
	endfunction

	// Random read: mostly clustered around a few regions so that tags get
	// reused and evicted, with some overlong, empty and out-of-file requests.
	function automatic void queue_random_read(input logic [OFFSET_W-1:0] region);
		logic [OFFSET_W-1:0] off;
		logic [LEN_W-1:0]    len;
		logic [OFFSET_W-1:0] flen;
		logic [OFFSET_W:0]   sum;
		logic [OFFSET_W-1:0] gap;
		int unsigned         roll;

		if ($urandom_range(0, 99) < 10)
			off = any_offset();
		else
			off = region + {TAG_W'($urandom_range(0, 23)), SLOT_W'($urandom)};

		roll = $urandom_range(0, 99);
		if (roll < 5)
			len = LEN_W'($urandom_range(32'h7FFFF, 32'h40001));
		else if (roll < 10)
			len = '0;
		else if (roll < 20)
			len = LEN_W'($urandom_range(32'h40000, 32'h30000));
		else
			len = LEN_W'($urandom_range(32'h14000, 1));

		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			// File ends at or before the offset.
			gap = OFFSET_W'($urandom_range(32'h20000, 0));
			flen = (off > gap) ? off - gap : '0;
		end else if (roll < 35) begin
			// File ends shortly past the offset: clipping is likely.
			sum = {1'b0, off} + $urandom_range(32'h30000, 1);
			flen = sum[OFFSET_W] ? TOP_OFFSET : sum[OFFSET_W-1:0];
		end else if (roll < 45) begin
			flen = any_offset();
		end else begin
			flen = TOP_OFFSET;
		end
		queue_read(off, len, flen);
	endfunction

	// Build the whole run: directed requests, then random phases with the
	// prefetch switch flipped between them.
	initial begin
		logic [OFFSET_W-1:0] regions [4];
		logic                phase_pf [3];
		int                  phase_len [3];

		// Prefetch off, as after reset.
		queue_read('0, '0, '0);
		queue_read(TOP_OFFSET, '1, TOP_OFFSET);
		queue_read(40'h100, 19'h40, 40'h80);
		queue_read('0, 19'h10000, TOP_OFFSET);
		queue_read('0, 19'h10000, TOP_OFFSET);
		queue_read(40'h8000, '0, TOP_OFFSET);
		queue_read(40'h1234, LEN_CAP, TOP_OFFSET);
		queue_read(40'h30000, '1, TOP_OFFSET);
		queue_read(40'h10000, 19'h30000, 40'h18000);
		queue_read(TOP_OFFSET - 1'b1, '1, TOP_OFFSET);
		queue_read(40'h10_0000, 19'h8000, TOP_OFFSET);

		queue_ctrl(STEP_CFG, 1'b1);
		queue_read(40'h10_0000_8000, '0, TOP_OFFSET);
		queue_read(40'h10_0000_8000, '0, TOP_OFFSET);
		queue_read(40'h20_0000_0000, 19'hC000, TOP_OFFSET);
		queue_read(40'h20_0000_0000, 19'hC000, TOP_OFFSET);
		queue_read(40'h20_0002_0000, 19'h100, TOP_OFFSET);
		queue_read(40'hFF_FFFF_8000, 19'h4000, TOP_OFFSET);
		queue_read(40'h30_0000_0000, 19'h10000, TOP_OFFSET);
		queue_read(40'h40_0000_0000, 19'h8000, TOP_OFFSET);
		queue_read(40'h50_0000_F000, LEN_CAP, 40'h50_0002_C000);

		queue_ctrl(STEP_CFG, 1'b0);
		queue_read(40'h60_0000_0000, 19'hC000, TOP_OFFSET);

		regions[0] = '0;
		regions[1] = TOP_OFFSET - 40'h1F_FFFF;
		regions[2] = any_offset() & {{TAG_W{1'b1}}, {SLOT_W{1'b0}}};
		regions[3] = any_offset() & {{TAG_W{1'b1}}, {SLOT_W{1'b0}}};
		phase_pf  = '{1'b1, 1'b0, 1'b1};
		phase_len = '{90, 70, 90};
		for (int p = 0; p < 3; p++) begin
			queue_ctrl(STEP_CFG, phase_pf[p]);
			for (int i = 0; i < phase_len[p]; i++) begin
				// Let the pipe run dry once per phase.
				if (i == phase_len[p] / 2)
					queue_ctrl(STEP_DRAIN, 1'b0);
				queue_random_read(regions[$urandom_range(0, 3)]);
			end
		end

		while (host_steps.size() != 0 || due_items.size() != 0 || busy)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Driver: retire the transaction taken at this edge, then decide what the
	// request and config channels carry next. start and cfg_valid each get one
	// nonblocking update per edge so that back-to-back transactions hold high.
	always @(posedge clk) begin : driver
		host_step_t step;
		logic       nx_start;
		logic       nx_cfg;
		logic       quiet;

		if (!arst_n) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nx_start = start && busy;
			nx_cfg   = cfg_valid && !cfg_ready;
			if (start && !busy) begin
				step = host_steps.pop_front();
				split_and_lookup(step.off, step.len, step.flen);
				reads_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				void'(host_steps.pop_front());
				prefetch_on = cfg_data;
			end

			if (!nx_start && !nx_cfg && host_steps.size() != 0) begin
				step = host_steps[0];
				quiet = reads_sent >= QUIET_FROM && reads_sent < QUIET_TO;
				if (step.what == STEP_READ) begin
					// Drop start now and then, except in the quiet stretch.
					if (quiet || $urandom_range(0, 99) >= 10) begin
						nx_start = 1'b1;
						request_offset <= step.off;
						request_length <= step.len;
						file_size      <= step.flen;
					end
				end else if (busy || result_valid || due_items.size() != 0) begin
					// Hold config writes and drains until the block is idle.
					settle_cnt = 0;
				end else if (settle_cnt < SETTLE_CYCLES) begin
					settle_cnt++;
				end else begin
					settle_cnt = 0;
					if (step.what == STEP_CFG) begin
						nx_cfg = 1'b1;
						cfg_data <= step.pf;
					end else begin
						void'(host_steps.pop_front());
					end
				end
			end
			start     <= nx_start;
			cfg_valid <= nx_cfg;
		end
	end

	// Monitor: every strobed result is checked against the oldest prediction.
	always @(posedge clk) begin : monitor
		read_item_t want;

		if (arst_n && result_valid) begin
			if (due_items.size() == 0) begin
				note_mismatch("result with nothing due", 64'(block_address), '0);
			end else begin
				want = due_items.pop_front();
				if (kind !== want.kind)
					note_mismatch("kind", 64'(kind), 64'(want.kind));
				if (slot_index !== want.slot)
					note_mismatch("slot_index", 64'(slot_index), 64'(want.slot));
				if (block_address !== want.addr)
					note_mismatch("block_address", 64'(block_address), 64'(want.addr));
				if (start_in_slot !== want.offs)
					note_mismatch("start_in_slot", 64'(start_in_slot), 64'(want.offs));
				if (chunk_length !== want.clen)
					note_mismatch("chunk_length", 64'(chunk_length), 64'(want.clen));
				if (read_length !== want.rlen)
					note_mismatch("read_length", 64'(read_length), 64'(want.rlen));
				if (last !== want.fin)
					note_mismatch("last", 64'(last), 64'(want.fin));
			end
		end
	end

	// Watchdog: end the run if no transaction of any kind moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

endmodule
